>>> rtl/spectral_phase_derivative_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the spectral phase derivative block.
// ----------------------------------------------------------------------------
`ifndef SPECTRAL_PHASE_DERIVATIVE_ASSERT_SVH
`define SPECTRAL_PHASE_DERIVATIVE_ASSERT_SVH

// same-cycle implication
`define SPD_ASSERT_IMPLY(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("spd assertion failed");

// next-cycle implication
`define SPD_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("spd assertion failed");

`endif

>>> rtl/spd_pkg.sv
// ----------------------------------------------------------------------------
// spd_pkg
// Types, constants and helpers of the spectral phase derivative block.
// ----------------------------------------------------------------------------
package spd_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam logic [19:0] INV_GAIN_Q20 = 20'd636751;
    localparam logic [31:0] QUARTER_POS = 32'h4000_0000;
    localparam logic [31:0] QUARTER_NEG = 32'hC000_0000;

    // register indexes
    localparam logic [1:0] REG_LOG2_FRAME_BINS = 2'd0;
    localparam logic [1:0] REG_HOP_ANALYSIS    = 2'd1;
    localparam logic [1:0] REG_RECIP_HOP       = 2'd2;
    localparam logic [1:0] REG_RECIP_BIN_WIDTH = 2'd3;

    // register reset values
    localparam logic [3:0]  RST_LOG2_FRAME_BINS = 4'd10;
    localparam logic [10:0] RST_HOP_ANALYSIS    = 11'd256;
    localparam logic [24:0] RST_RECIP_HOP       = 25'd65536;
    localparam logic [23:0] RST_RECIP_BIN_WIDTH = 24'd65536;

    typedef struct packed {
        logic [3:0]  log2_frame_bins;
        logic [10:0] hop_analysis;
        logic [24:0] recip_hop;
        logic [23:0] recip_bin_width;
    } cfg_t;

    // CORDIC angle of step i in 2^-32 turns
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] a;
        case (i)
            5'd0:  a = 32'd536870912;
            5'd1:  a = 32'd316933406;
            5'd2:  a = 32'd167458907;
            5'd3:  a = 32'd85004756;
            5'd4:  a = 32'd42667331;
            5'd5:  a = 32'd21354465;
            5'd6:  a = 32'd10679838;
            5'd7:  a = 32'd5340245;
            5'd8:  a = 32'd2670163;
            5'd9:  a = 32'd1335087;
            5'd10: a = 32'd667544;
            5'd11: a = 32'd333772;
            5'd12: a = 32'd166886;
            5'd13: a = 32'd83443;
            5'd14: a = 32'd41722;
            5'd15: a = 32'd20861;
            5'd16: a = 32'd10430;
            5'd17: a = 32'd5215;
            5'd18: a = 32'd2608;
            5'd19: a = 32'd1304;
            5'd20: a = 32'd652;
            5'd21: a = 32'd326;
            5'd22: a = 32'd163;
            5'd23: a = 32'd81;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

    // clamp to signed 32 bits
    function automatic logic [31:0] sat32(input logic signed [39:0] v);
        logic [31:0] r;
        if (v > 40'sd2147483647)
            r = 32'h7FFF_FFFF;
        else if (v < -40'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

>>> rtl/spd_fifo.sv
// ----------------------------------------------------------------------------
// spd_fifo
// Small register FIFO with fill count; carries items between stages.
// ----------------------------------------------------------------------------
module spd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     rd_en,
    output logic [WIDTH-1:0]         rdata,
    output logic                     full,
    output logic                     empty,
    output logic [$clog2(DEPTH):0]   count
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;

    assign full  = (count_reg == (AW+1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign count = count_reg;
    assign rdata = mem[rd_ptr_reg];

    // store incoming item
    always_ff @(posedge clk)
    begin
        if (wr_en && !full)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    // advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en && !full)
            begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (rd_en && !empty)
            begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            count_reg <= count_reg + (AW+1)'(wr_en && !full) - (AW+1)'(rd_en && !empty);
        end
    end

endmodule

>>> rtl/spd_front.sv
// ----------------------------------------------------------------------------
// spd_front
// Accepts bins, tags them with bin index and frame end, and runs an
// iterative CORDIC for phase and magnitude.
// ----------------------------------------------------------------------------
module spd_front #(
    parameter int SAMPLE_BITS = 24,
    parameter int PHASE_BITS  = 16,
    parameter int MAX_BINS    = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           take,
    input  logic signed [SAMPLE_BITS-1:0]  re,
    input  logic signed [SAMPLE_BITS-1:0]  im,
    input  spd_pkg::cfg_t                  cfg,
    output logic                           busy,
    output logic                           item_valid,
    input  logic                           item_room,
    output logic [$clog2(MAX_BINS)-1:0]    item_k,
    output logic                           item_last,
    output logic [3:0]                     item_lg,
    output logic [PHASE_BITS-1:0]          item_ph,
    output logic [23:0]                    item_mag
);

    import spd_pkg::*;

    localparam int KW  = $clog2(MAX_BINS);
    localparam int XW  = SAMPLE_BITS + 9;
    localparam int PMW = XW + 45;
    localparam logic [31:0] RND = 32'd1 << (31 - PHASE_BITS);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_ITER = 2'd1;
    localparam logic [1:0] F_MAG  = 2'd2;
    localparam logic [1:0] F_DONE = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic signed [XW-1:0] x_reg, y_reg;
    logic [31:0]          z_reg;
    logic [4:0]           i_reg;
    logic                 zero_reg;
    logic [PMW-1:0]       pm_reg;
    logic [KW-1:0]        cnt_reg;
    logic [KW-1:0]        k_reg;
    logic                 last_reg;
    logic [3:0]           lg_reg;

    logic signed [XW-1:0] x0, y0, xs, ys, dx, dy;
    logic [31:0]          zs, zr;
    logic [3:0]           lg;
    logic [KW:0]          lim;
    logic                 last;

    // clamp frame size and find the frame end
    always_comb
    begin
        lg = (cfg.log2_frame_bins < 4'd3) ? 4'd3 : cfg.log2_frame_bins;
        if (lg > 4'(KW))
        begin
            lg = 4'(KW);
        end
        lim  = ((KW+1)'(1) << lg) - (KW+1)'(1);
        last = ({1'b0, cnt_reg} >= lim);
    end

    // pre-rotate left half plane by a quarter turn
    always_comb
    begin
        x0 = XW'(re) <<< 6;
        y0 = XW'(im) <<< 6;
        xs = x0;
        ys = y0;
        zs = '0;
        if (x0 < 0)
        begin
            if (y0 >= 0)
            begin
                xs = y0;
                ys = -x0;
                zs = QUARTER_POS;
            end
            else
            begin
                xs = -y0;
                ys = x0;
                zs = QUARTER_NEG;
            end
        end
    end

    assign dx = y_reg >>> i_reg;
    assign dy = x_reg >>> i_reg;
    assign zr = z_reg + RND;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: if (take) state_next = F_ITER;
            F_ITER: if (i_reg == 5'(CORDIC_STEPS - 1)) state_next = F_MAG;
            F_MAG:  state_next = F_DONE;
            F_DONE: if (item_room) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == F_IDLE && take)
            begin
                cnt_reg <= last ? '0 : cnt_reg + KW'(1);
            end
        end
    end

    // CORDIC datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
            begin
                x_reg    <= xs;
                y_reg    <= ys;
                z_reg    <= zs;
                i_reg    <= '0;
                zero_reg <= (re == '0) && (im == '0);
                k_reg    <= cnt_reg;
                last_reg <= last;
                lg_reg   <= lg;
            end
            F_ITER:
            begin
                if (!y_reg[XW-1])
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + atan_turn(i_reg);
                end
                else
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - atan_turn(i_reg);
                end
                i_reg <= i_reg + 5'd1;
            end
            F_MAG:
            begin
                // negative x gives zero magnitude
                if (x_reg[XW-1])
                    pm_reg <= '0;
                else
                    pm_reg <= PMW'($unsigned(x_reg)) * PMW'(INV_GAIN_Q20) + (PMW'(1) << 25);
            end
            default:
            begin
            end
        endcase
    end

    assign busy       = (state_reg != F_IDLE);
    assign item_valid = (state_reg == F_DONE);
    assign item_k     = k_reg;
    assign item_last  = last_reg;
    assign item_lg    = lg_reg;
    assign item_ph    = zero_reg ? '0 : zr[31 -: PHASE_BITS];
    assign item_mag   = zero_reg ? 24'd0 :
                        ((|pm_reg[PMW-1:50]) ? 24'hFF_FFFF : pm_reg[49:26]);

endmodule

>>> rtl/spd_back.sv
// ----------------------------------------------------------------------------
// spd_back
// Computes time and frequency derivatives from the prior frame's phases
// and the neighbour bins, and emits the delayed results.
// ----------------------------------------------------------------------------
`include "spectral_phase_derivative_assert.svh"

module spd_back #(
    parameter int PHASE_BITS = 16,
    parameter int MAX_BINS   = 1024,
    parameter int OUT_DEPTH  = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  spd_pkg::cfg_t                  cfg,
    output logic                           clearing,
    input  logic                           q_empty,
    output logic                           q_pop,
    input  logic [$clog2(MAX_BINS)-1:0]    q_k,
    input  logic                           q_last,
    input  logic [3:0]                     q_lg,
    input  logic [PHASE_BITS-1:0]          q_ph,
    input  logic [23:0]                    q_mag,
    input  logic [$clog2(OUT_DEPTH):0]     out_count,
    output logic                           out_push,
    output logic [9:0]                     out_bin,
    output logic [23:0]                    out_mag,
    output logic [PHASE_BITS-1:0]          out_ph,
    output logic [31:0]                    out_td,
    output logic [31:0]                    out_fd,
    output logic                           out_end
);

    import spd_pkg::*;

    localparam int KW  = $clog2(MAX_BINS);
    localparam int PB  = PHASE_BITS;
    localparam int PSH = 32 - PB;
    localparam int SSH = 24 - PB;
    localparam int SPW = PB + 25;
    localparam int CW  = $clog2(OUT_DEPTH);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_S1   = 3'd1;
    localparam logic [2:0] B_S2   = 3'd2;
    localparam logic [2:0] B_S3   = 3'd3;
    localparam logic [2:0] B_S4   = 3'd4;
    localparam logic [2:0] B_P1   = 3'd5;
    localparam logic [2:0] B_P2   = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic                  clear_reg;
    logic [KW-1:0]         clr_cnt_reg;
    logic [PB-1:0]         mem [MAX_BINS];
    logic [PB-1:0]         rd_reg;

    logic [KW-1:0]         k_reg;
    logic                  last_reg;
    logic [3:0]            lg_reg;
    logic [PB-1:0]         ph_reg;
    logic [23:0]           mag_reg;

    logic [PB-1:0]         pd_reg;
    logic [KW+10:0]        hk_reg;
    logic signed [SPW-1:0] pf_reg, pb_reg;
    logic [31:0]           d_reg;
    logic signed [57:0]    prod_reg;
    logic signed [32:0]    sf_reg, sb_reg;
    logic [31:0]           td_reg, fd1_reg, fd2_reg;

    logic [PB-1:0]         held1_reg, held2_reg;
    logic [23:0]           held_mag_reg;
    logic [31:0]           held_td_reg;

    logic                  start;
    logic signed [25:0]    td_q;
    logic signed [39:0]    td_sum;
    logic signed [32:0]    back_s;
    logic signed [33:0]    pair;

    // phase slope scaled to 24 fraction bits, rounded half up
    function automatic logic signed [32:0] scale(input logic signed [SPW-1:0] p);
        logic signed [48:0] v;
        logic signed [48:0] r;
        v = 49'(p) <<< SSH;
        r = (v + 49'sd32768) >>> 16;
        return r[32:0];
    endfunction

    assign clearing = clear_reg;
    assign start    = !clear_reg && !q_empty && (state_reg == B_IDLE)
                      && (out_count <= (CW+1)'(OUT_DEPTH - 2));
    assign q_pop    = start;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: if (start) state_next = B_S1;
            B_S1:   state_next = B_S2;
            B_S2:   state_next = B_S3;
            B_S3:   state_next = B_S4;
            B_S4:   state_next = B_P1;
            B_P1:   state_next = B_P2;
            B_P2:   state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // control state and neighbour history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            clear_reg    <= 1'b1;
            clr_cnt_reg  <= '0;
            held1_reg    <= '0;
            held2_reg    <= '0;
            held_mag_reg <= '0;
            held_td_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clear_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + KW'(1);
                if (clr_cnt_reg == KW'(MAX_BINS - 1))
                begin
                    clear_reg <= 1'b0;
                end
            end
            if (state_reg == B_P2)
            begin
                held2_reg    <= held1_reg;
                held1_reg    <= ph_reg;
                held_mag_reg <= mag_reg;
                held_td_reg  <= td_reg;
            end
        end
    end

    // prior frame phase memory
    always_ff @(posedge clk)
    begin
        if (clear_reg)
            mem[clr_cnt_reg] <= '0;
        else if (state_reg == B_S2)
            mem[k_reg] <= ph_reg;
        if (start)
            rd_reg <= mem[q_k];
    end

    // derivative results
    always_comb
    begin
        td_q   = 26'((prod_reg + 58'sh8000_0000) >>> 32);
        td_sum = 40'(td_q) + $signed(40'(k_reg) << (5'd24 - 5'(lg_reg)));
        back_s = (k_reg > KW'(1)) ? sb_reg : 33'sd0;
        pair   = 34'(back_s) + 34'(sf_reg);
    end

    // arithmetic pipeline
    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                if (start)
                begin
                    k_reg    <= q_k;
                    last_reg <= q_last;
                    lg_reg   <= q_lg;
                    ph_reg   <= q_ph;
                    mag_reg  <= q_mag;
                end
            end
            B_S1:
            begin
                pd_reg <= ph_reg - rd_reg;
                hk_reg <= (KW+11)'(cfg.hop_analysis) * (KW+11)'(k_reg);
                pf_reg <= $signed(ph_reg - held1_reg) * $signed({1'b0, cfg.recip_bin_width});
            end
            B_S2:
            begin
                d_reg  <= {pd_reg, PSH'(0)}
                          - (32'(hk_reg) << (6'd32 - 6'(lg_reg)));
                pb_reg <= $signed(held1_reg - held2_reg) * $signed({1'b0, cfg.recip_bin_width});
            end
            B_S3:
            begin
                prod_reg <= $signed(d_reg) * $signed({1'b0, cfg.recip_hop});
                sf_reg   <= scale(pf_reg);
                sb_reg   <= scale(pb_reg);
            end
            B_S4:
            begin
                td_reg <= sat32(td_sum);
                // average only when both sides carry a slope
                if (back_s != 0 && sf_reg != 0)
                    fd1_reg <= sat32(40'(pair >>> 1));
                else if (back_s != 0)
                    fd1_reg <= sat32(40'(back_s));
                else
                    fd1_reg <= sat32(40'(sf_reg));
                fd2_reg <= (k_reg != '0) ? sat32(40'(sf_reg)) : 32'd0;
            end
            default:
            begin
            end
        endcase
    end

    // emit the held bin, then the last bin at frame end
    always_comb
    begin
        out_push = 1'b0;
        out_bin  = 10'(k_reg);
        out_mag  = mag_reg;
        out_ph   = ph_reg;
        out_td   = td_reg;
        out_fd   = fd2_reg;
        out_end  = 1'b1;
        if (state_reg == B_P1)
        begin
            out_push = (k_reg != '0);
            out_bin  = 10'(k_reg - KW'(1));
            out_mag  = held_mag_reg;
            out_ph   = held1_reg;
            out_td   = held_td_reg;
            out_fd   = fd1_reg;
            out_end  = 1'b0;
        end
        else if (state_reg == B_P2)
        begin
            out_push = last_reg;
        end
    end

    `SPD_ASSERT_IMPLY(a_room_for_two, clk, rst_n, start, out_count <= (CW+1)'(OUT_DEPTH - 2))
    `SPD_ASSERT_IMPLY(a_no_work_while_clear, clk, rst_n, clear_reg, state_reg == B_IDLE)
    `SPD_ASSERT_NEXT(a_clear_once, clk, rst_n, !clear_reg, !clear_reg)
    `SPD_ASSERT_IMPLY(a_end_only_last, clk, rst_n, out_push && out_end, last_reg)

endmodule

>>> rtl/spectral_phase_derivative.sv
// ----------------------------------------------------------------------------
// spectral_phase_derivative
// Phase vocoder phase-gradient estimation over a stream of FFT bins.
// ----------------------------------------------------------------------------
// Each bin runs through the 24-step iterative CORDIC of the front end that
// produces phase and magnitude; the front end takes no new bin until it is
// done with the last one. The back end runs in parallel behind a two-entry
// queue. After reset the block clears the prior-frame phase memory and holds
// full high meanwhile. Results lag one bin; the last bin of a frame yields two.
module spectral_phase_derivative #(
    parameter int SAMPLE_BITS = 24,
    parameter int PHASE_BITS  = 16,
    parameter int MAX_BINS    = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [SAMPLE_BITS-1:0] bin_real,
    input  logic signed [SAMPLE_BITS-1:0] bin_imag,
    output logic                          empty,
    input  logic                          pop,
    output logic [9:0]                    bin_index,
    output logic [23:0]                   magnitude,
    output logic signed [PHASE_BITS-1:0]  phase,
    output logic signed [31:0]            time_derivative,
    output logic signed [31:0]            freq_derivative,
    output logic                          frame_end,
    input  logic                          wr_en,
    input  logic [1:0]                    wr_index,
    input  logic [24:0]                   wr_data
);

    import spd_pkg::*;

    localparam int KW     = $clog2(MAX_BINS);
    localparam int QW     = KW + 1 + 4 + PHASE_BITS + 24;
    localparam int OW     = 10 + 24 + PHASE_BITS + 32 + 32 + 1;
    localparam int QDEPTH = 2;
    localparam int ODEPTH = 4;

    cfg_t cfg_reg;

    logic                  front_busy, clearing, take;
    logic                  f_valid, q_full, q_empty, q_pop;
    logic [KW-1:0]         f_k, q_k;
    logic                  f_last, q_last;
    logic [3:0]            f_lg, q_lg;
    logic [PHASE_BITS-1:0] f_ph, q_ph;
    logic [23:0]           f_mag, q_mag;
    logic [$clog2(QDEPTH):0] q_count;

    logic                  o_push, o_full;
    logic [9:0]            o_bin;
    logic [23:0]           o_mag;
    logic [PHASE_BITS-1:0] o_ph;
    logic [31:0]           o_td, o_fd;
    logic                  o_end;
    logic [$clog2(ODEPTH):0] o_count;
    logic [OW-1:0]         o_rdata;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.log2_frame_bins <= RST_LOG2_FRAME_BINS;
            cfg_reg.hop_analysis    <= RST_HOP_ANALYSIS;
            cfg_reg.recip_hop       <= RST_RECIP_HOP;
            cfg_reg.recip_bin_width <= RST_RECIP_BIN_WIDTH;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_LOG2_FRAME_BINS: cfg_reg.log2_frame_bins <= wr_data[3:0];
                REG_HOP_ANALYSIS:    cfg_reg.hop_analysis    <= wr_data[10:0];
                REG_RECIP_HOP:       cfg_reg.recip_hop       <= wr_data;
                REG_RECIP_BIN_WIDTH: cfg_reg.recip_bin_width <= wr_data[23:0];
                default:
                begin
                end
            endcase
        end
    end

    assign full = front_busy || clearing;
    assign take = push && !full;

    spd_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .PHASE_BITS  (PHASE_BITS),
        .MAX_BINS    (MAX_BINS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .re         (bin_real),
        .im         (bin_imag),
        .cfg        (cfg_reg),
        .busy       (front_busy),
        .item_valid (f_valid),
        .item_room  (!q_full),
        .item_k     (f_k),
        .item_last  (f_last),
        .item_lg    (f_lg),
        .item_ph    (f_ph),
        .item_mag   (f_mag)
    );

    spd_fifo #(
        .WIDTH (QW),
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (f_valid),
        .wdata ({f_k, f_last, f_lg, f_ph, f_mag}),
        .rd_en (q_pop),
        .rdata ({q_k, q_last, q_lg, q_ph, q_mag}),
        .full  (q_full),
        .empty (q_empty),
        .count (q_count)
    );

    spd_back #(
        .PHASE_BITS (PHASE_BITS),
        .MAX_BINS   (MAX_BINS),
        .OUT_DEPTH  (ODEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .clearing  (clearing),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .q_k       (q_k),
        .q_last    (q_last),
        .q_lg      (q_lg),
        .q_ph      (q_ph),
        .q_mag     (q_mag),
        .out_count (o_count),
        .out_push  (o_push),
        .out_bin   (o_bin),
        .out_mag   (o_mag),
        .out_ph    (o_ph),
        .out_td    (o_td),
        .out_fd    (o_fd),
        .out_end   (o_end)
    );

    spd_fifo #(
        .WIDTH (OW),
        .DEPTH (ODEPTH)
    ) u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (o_push),
        .wdata ({o_bin, o_mag, o_ph, o_td, o_fd, o_end}),
        .rd_en (pop),
        .rdata (o_rdata),
        .full  (o_full),
        .empty (empty),
        .count (o_count)
    );

    assign {bin_index, magnitude, phase, time_derivative, freq_derivative, frame_end} = o_rdata;

    // o_full and q_count are otherwise unused; fill levels are watched through q_full, q_empty and o_count
    logic unused_ok;
    assign unused_ok = o_full ^ q_count[0];

endmodule
